// ===== design/ias_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ias_pkg
// Shared types and codes for the IPv4 address set core.
// ----------------------------------------------------------------------------
package ias_pkg;

    localparam int ADDR_W = 32;
    localparam int OP_W   = 2;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_APPLY
    } ias_state_t;

    typedef struct packed {
        logic load;
        logic clear;
        logic scan;
        logic apply;
    } ias_cmd_t;

    typedef struct packed {
        logic last_idx;
        logic out_free;
    } ias_stat_t;

endpackage

// ===== design/ipv4_address_set_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_address_set_core
// Fixed-capacity set of IPv4 addresses with insert, remove and lookup.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// s_axis    in         op, address
// m_axis    out        found, status
//
// An item occupies the core from acceptance through its scan, drain and update,
// and the next item is taken only after that update: the slot memory has one
// read port and every slot is read once per item.
// After reset a clearing pass over every slot runs before the first item
// is taken. A result waits in the output register; the next item is accepted
// and scanned meanwhile, and only its update stalls until the result is taken.
// ----------------------------------------------------------------------------
module ipv4_address_set_core
    import ias_pkg::*;
#(
    parameter int CAPACITY = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // op [1:0], address [33:2], zero [39:34]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // found [0], status [1], zero [7:2]
);

    ias_cmd_t  cmd;
    ias_stat_t stat;
    logic      out_found;
    logic      out_status;

    ias_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ias_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_op      (s_tdata[1:0]),
        .in_address (s_tdata[33:2]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .out_found  (out_found),
        .out_status (out_status)
    );

    assign m_tdata = {6'b0, out_status, out_found};

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.clear && s_tready))
        else $error("Input item accepted during the clearing pass.");

    a_apply_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.apply |=> m_tvalid)
        else $error("Update did not present a result.");

    a_result_from_apply: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd.apply))
        else $error("Result appeared without an update.");

    a_reject_not_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1]) |-> !m_tdata[0])
        else $error("Rejected insert reported the address as present.");

endmodule

// ===== design/ias_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ias_ctrl
// Sequencer for the set: clearing pass after reset, then per item a scan of
// every slot, a pipeline drain state and an update with the result.
// ----------------------------------------------------------------------------
module ias_ctrl
    import ias_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  ias_stat_t stat,
    output ias_cmd_t  cmd
);

    ias_state_t state_reg;
    ias_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (stat.last_idx) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (stat.last_idx) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                state_next = ST_APPLY;
            end
            ST_APPLY: begin
                if (stat.out_free) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        s_tready  = 1'b0;
        cmd       = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
            end
            ST_DRAIN: begin
            end
            ST_APPLY: begin
                cmd.apply = stat.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== design/ias_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ias_datapath
// Slot memory holding a valid bit and an address per slot, scan index,
// compare logic and the result register.
// ----------------------------------------------------------------------------
module ias_datapath
    import ias_pkg::*;
#(
    parameter int CAPACITY = 256
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  ias_cmd_t          cmd,
    output ias_stat_t         stat,
    input  logic [OP_W-1:0]   in_op,
    input  logic [ADDR_W-1:0] in_address,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic              out_found,
    output logic              out_status
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

    logic [ADDR_W:0]    mem [CAPACITY];

    logic [IDX_W-1:0]   idx_reg;
    logic [ADDR_W:0]    rd_data_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic               rd_live_reg;

    logic [OP_W-1:0]    op_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic               hit_reg;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic               free_reg;
    logic [IDX_W-1:0]   free_idx_reg;

    logic               m_tvalid_reg;
    logic               found_reg;
    logic               status_reg;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_idx;
    logic [ADDR_W:0]    wr_data;
    logic               do_insert;
    logic               do_remove;
    logic               reject;

    assign stat.last_idx = (idx_reg == LAST_IDX);
    assign stat.out_free = !m_tvalid_reg || m_tready;

    assign do_insert = (op_reg == OP_INSERT) && !hit_reg && free_reg;
    assign do_remove = (op_reg == OP_REMOVE) && hit_reg;
    assign reject    = (op_reg == OP_INSERT) && !hit_reg && !free_reg;

    always_comb begin
        wr_en   = 1'b0;
        wr_idx  = idx_reg;
        wr_data = '0;
        if (cmd.clear) begin
            wr_en = 1'b1;
        end else if (cmd.apply && do_insert) begin
            wr_en   = 1'b1;
            wr_idx  = free_idx_reg;
            wr_data = {1'b1, addr_reg};
        end else if (cmd.apply && do_remove) begin
            wr_en   = 1'b1;
            wr_idx  = hit_idx_reg;
            wr_data = {1'b0, addr_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
        rd_data_reg <= mem[idx_reg];
        rd_idx_reg  <= idx_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            rd_live_reg <= 1'b0;
        end else begin
            rd_live_reg <= cmd.scan;
            if (cmd.load) begin
                idx_reg <= '0;
            end else if (cmd.scan || cmd.clear) begin
                idx_reg <= stat.last_idx ? '0 : idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= in_op;
            addr_reg <= in_address;
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end else if (rd_live_reg) begin
            if (rd_data_reg[ADDR_W] && (rd_data_reg[ADDR_W-1:0] == addr_reg) && !hit_reg) begin
                hit_reg     <= 1'b1;
                hit_idx_reg <= rd_idx_reg;
            end
            if (!rd_data_reg[ADDR_W] && !free_reg) begin
                free_reg     <= 1'b1;
                free_idx_reg <= rd_idx_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.apply) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.apply) begin
            found_reg  <= hit_reg;
            status_reg <= reject;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign out_found  = found_reg;
    assign out_status = status_reg;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for ipv4_address_set_core. The bench sends a short
// directed sequence of insert, remove and lookup items. It then sends random
// traffic that fills the store until inserts are rejected, mixes all
// operations, and drains the store again. A membership predictor computes the
// found and status fields of every accepted item, and the monitor checks each
// result against them in order. The sender and the receiver pause at random,
// and some pauses last longer than a whole scan.
// ----------------------------------------------------------------------------
module testbench;
    import ias_pkg::*;

    localparam int SET_CAPACITY = 256;
    localparam int ITEM_LATENCY = SET_CAPACITY + 3;
    localparam int POOL_SIZE    = 320;
    localparam int LONG_GAP_MAX = 400;
    localparam int RUN_LIMIT    = 3_000_000;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [OP_W-1:0]   op;
    } set_request_t;

    typedef struct packed {
        logic status;
        logic found;
    } set_reply_t;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_ANY
    } traffic_mix_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // op [1:0], address [33:2], zero [39:34]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // found [0], status [1], zero [7:2]

    bit                member_set [bit [ADDR_W-1:0]];
    set_request_t      pending_requests [$];
    set_reply_t        expected_replies [$];
    logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int send_gap           = 0;
    int stall_left         = 0;
    int fill_ptr           = 0;
    int error_count        = 0;
    int cycle_count        = 0;

    set_request_t next_req;
    set_reply_t   got_reply;
    set_reply_t   want_reply;

    ipv4_address_set_core #(
        .CAPACITY(SET_CAPACITY)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Membership only matters here: which slot holds an address is not
    // visible at the ports, and fullness depends on the count alone.
    function automatic set_reply_t apply_request(set_request_t req);
        set_reply_t rep;
        rep.found  = (member_set.exists(req.address) != 0);
        rep.status = STATUS_OK;
        case (req.op)
            OP_INSERT: begin
                if (!rep.found) begin
                    if (member_set.num() >= SET_CAPACITY) begin
                        rep.status = STATUS_FULL;
                    end else begin
                        member_set[req.address] = 1'b1;
                    end
                end
            end
            OP_REMOVE: begin
                if (rep.found) begin
                    member_set.delete(req.address);
                end
            end
            default: begin
            end
        endcase
        return rep;
    endfunction

    function automatic int idle_length();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(1, LONG_GAP_MAX)
                                            : $urandom_range(1, 4);
    endfunction

    function automatic set_request_t any_request();
        set_request_t req;
        req.op = OP_W'($urandom_range(0, 3));
        if ($urandom_range(0, 99) < 85) begin
            req.address = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else begin
            req.address = $urandom();
        end
        return req;
    endfunction

    task automatic push_request(logic [OP_W-1:0] op, logic [ADDR_W-1:0] address);
        set_request_t req;
        req.op      = op;
        req.address = address;
        pending_requests.push_back(req);
    endtask

    task automatic push_traffic(traffic_mix_t mix, int count);
        set_request_t req;
        for (int i = 0; i < count; i++) begin
            req = any_request();
            case (mix)
                MIX_FILL: begin
                    if ($urandom_range(0, 9) != 0) begin
                        req.op      = OP_INSERT;
                        req.address = addr_pool[fill_ptr];
                        fill_ptr    = (fill_ptr + 1) % POOL_SIZE;
                    end
                end
                MIX_DRAIN: begin
                    if ($urandom_range(0, 9) < 8) begin
                        req.op      = OP_REMOVE;
                        req.address = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
                    end
                end
                default: begin
                end
            endcase
            pending_requests.push_back(req);
        end
    endtask

    task automatic wait_for_send();
        while (pending_requests.size() != 0 || s_tvalid) begin
            @(negedge aclk);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap = 0;
        end else if (!s_tvalid || s_tready) begin
            if (send_gap > 0 || pending_requests.size() == 0) begin
                if (send_gap > 0) begin
                    send_gap--;
                end
                s_tvalid <= 1'b0;
            end else begin
                next_req = pending_requests.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {6'b0, next_req};
                send_gap = ($urandom_range(0, 99) < sender_idle_pct) ? idle_length() : 0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 99) < receiver_stall_pct) begin
            stall_left = idle_length() - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // The result is checked before the item accepted at the same edge is
    // predicted, so that a spurious result never meets a fresh expectation.
    always @(posedge aclk) begin
        cycle_count++;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got_reply = set_reply_t'(m_tdata[1:0]);
                if (expected_replies.size() == 0) begin
                    error_count++;
                    $display("%0t: result with none expected: found %0b status %0b",
                             $time, got_reply.found, got_reply.status);
                end else begin
                    want_reply = expected_replies.pop_front();
                    if (got_reply.found !== want_reply.found) begin
                        error_count++;
                        $display("%0t: found mismatch: expected %0b actual %0b",
                                 $time, want_reply.found, got_reply.found);
                    end
                    if (got_reply.status !== want_reply.status) begin
                        error_count++;
                        $display("%0t: status mismatch: expected %0b actual %0b",
                                 $time, want_reply.status, got_reply.status);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_replies.push_back(apply_request(set_request_t'(s_tdata[33:0])));
            end
        end
    end

    initial begin
        wait (cycle_count >= RUN_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) begin
            addr_pool[i] = (i < 128) ? (32'hC0A8_0000 | 32'(i)) : $urandom();
        end

        push_request(OP_LOOKUP, 32'h0000_0000);
        push_request(OP_INSERT, 32'h0000_0000);
        push_request(OP_INSERT, 32'hFFFF_FFFF);
        push_request(OP_LOOKUP, 32'h0000_0000);
        push_request(OP_LOOKUP, 32'hFFFF_FFFF);
        push_request(OP_INSERT, 32'h0000_0000);
        push_request(OP_LOOKUP, 32'hFFFF_FFFE);
        push_request(OP_REMOVE, 32'h1234_5678);
        push_request(OP_REMOVE, 32'hFFFF_FFFF);
        push_request(OP_LOOKUP, 32'hFFFF_FFFF);
        push_request(OP_UNUSED, 32'h0000_0000);
        push_request(OP_UNUSED, 32'hFFFF_FFFF);
        push_request(OP_INSERT, 32'h8000_0000);
        push_request(OP_INSERT, 32'h7FFF_FFFF);
        push_request(OP_INSERT, 32'hA5A5_A5A5);
        push_request(OP_INSERT, 32'h5A5A_5A5A);
        push_request(OP_REMOVE, 32'h0000_0000);
        push_request(OP_INSERT, 32'h0000_0000);
        push_request(OP_LOOKUP, 32'h8000_0000);
        push_request(OP_REMOVE, 32'h8000_0000);
        push_traffic(MIX_FILL, 300);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        wait_for_send();

        sender_idle_pct = 66;
        push_traffic(MIX_ANY, 250);
        wait_for_send();

        sender_idle_pct    = 0;
        receiver_stall_pct = 66;
        push_traffic(MIX_DRAIN, 250);
        wait_for_send();

        sender_idle_pct    = 36;
        receiver_stall_pct = 36;
        push_traffic(MIX_ANY, 250);
        wait_for_send();

        while (expected_replies.size() != 0) begin
            @(negedge aclk);
        end
        repeat (2 * ITEM_LATENCY) @(posedge aclk);

        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
